// ===== rtl/core/icalc_pkg.sv =====
// ----------------------------------------------------------------------------
// icalc_pkg
// shared codes, state encoding and handshake types of the integer calculator
// ----------------------------------------------------------------------------
package icalc_pkg;

   localparam int DATA_WIDTH_DEF = 32;

   typedef logic [2:0] opcode_type;
   typedef logic [1:0] status_type;

   localparam opcode_type OP_ADD  = 3'd0;
   localparam opcode_type OP_SUB  = 3'd1;
   localparam opcode_type OP_MUL  = 3'd2;
   localparam opcode_type OP_DIV  = 3'd3;
   localparam opcode_type OP_POW  = 3'd4;
   localparam opcode_type OP_SAME = 3'd5;
   localparam opcode_type OP_GCD  = 3'd6;
   localparam opcode_type OP_LCM  = 3'd7;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_DIVZERO  = 2'd1;
   localparam status_type ST_OVERFLOW = 2'd2;
   localparam status_type ST_ZERO     = 2'd3;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ADDSUB,
      S_ABSA,
      S_ABSB,
      S_PREP,
      S_DIV,
      S_DIVSGN,
      S_GTWO,
      S_GLOOP,
      S_LCMMUL,
      S_LCMFIN,
      S_MUL,
      S_MULFIN,
      S_PCHK,
      S_PACC,
      S_PSQ,
      S_PBASE,
      S_DONE
   } state_type;

   // core status toward the stream wrapper
   typedef struct packed {
      logic idle;
      logic done;
   } core_stat_type;

endpackage

// ===== rtl/core/icalc_addsub.sv =====
// ----------------------------------------------------------------------------
// icalc_addsub
// shared adder / subtractor used by every iterative operation
// ----------------------------------------------------------------------------
module icalc_addsub #(
   parameter int DATA_WIDTH = icalc_pkg::DATA_WIDTH_DEF
) (
   input  logic [DATA_WIDTH:0] x_i,
   input  logic [DATA_WIDTH:0] y_i,
   input  logic                sub_i,
   output logic [DATA_WIDTH:0] sum_o,
   output logic                carry_o
);
   import icalc_pkg::*;

   logic [DATA_WIDTH:0] y_eff;

   // subtract as x + ~y + 1, carry set means x >= y
   assign y_eff = sub_i ? ~y_i : y_i;
   assign {carry_o, sum_o} = {1'b0, x_i} + {1'b0, y_eff} + {{(DATA_WIDTH + 1){1'b0}}, sub_i};

endmodule

// ===== rtl/core/icalc_core.sv =====
// ----------------------------------------------------------------------------
// icalc_core
// sequencer and operand registers around the shared adder / subtractor
// ----------------------------------------------------------------------------
module icalc_core #(
   parameter int DATA_WIDTH = icalc_pkg::DATA_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start_i,
   input  icalc_pkg::opcode_type    opcode_i,
   input  logic [DATA_WIDTH-1:0]    left_i,
   input  logic [DATA_WIDTH-1:0]    right_i,
   input  logic                     take_i,
   output icalc_pkg::core_stat_type stat_o,
   output logic [DATA_WIDTH-1:0]    value_o,
   output icalc_pkg::status_type    status_o
);
   import icalc_pkg::*;

   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);
   localparam logic [DATA_WIDTH-1:0] MAXPOS = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] ONE = {{(DATA_WIDTH - 1){1'b0}}, 1'b1};
   localparam logic [DATA_WIDTH-1:0] ZERO = '0;

   state_type state_ff, state_in, ret_ff, ret_in;
   opcode_type op_ff, op_in;
   logic [DATA_WIDTH-1:0] a_ff, a_in, b_ff, b_in;
   logic [DATA_WIDTH-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [CNT_W-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] dq_ff, dq_in, drem_ff, drem_in, ddiv_ff, ddiv_in;
   logic [DATA_WIDTH-1:0] mca_ff, mca_in, mpl_ff, mpl_in, prod_ff, prod_in;
   logic [DATA_WIDTH-1:0] pacc_ff, pacc_in, res_ff, res_in;
   logic ovf_ff, ovf_in, neg_ff, neg_in;
   status_type st_ff, st_in;

   logic [DATA_WIDTH:0] ux, uy, usum;
   logic usub, ucarry;
   logic [DATA_WIDTH:0] rtmp;
   logic [DATA_WIDTH-1:0] gval;
   logic same;

   icalc_addsub #(.DATA_WIDTH(DATA_WIDTH)) u_addsub (
      .x_i    (ux),
      .y_i    (uy),
      .sub_i  (usub),
      .sum_o  (usum),
      .carry_o(ucarry)
   );

   assign rtmp = {drem_ff, dq_ff[DATA_WIDTH-1]};
   assign gval = gx_ff << k_ff;
   assign same = (!left_i[DATA_WIDTH-1] && left_i != ZERO &&
                  !right_i[DATA_WIDTH-1] && right_i != ZERO) ||
                 (left_i[DATA_WIDTH-1] && right_i[DATA_WIDTH-1]);

   // shared unit operand selection
   always_comb begin
      ux = '0;
      uy = '0;
      usub = 1'b0;
      unique case (state_ff)
         S_ADDSUB: begin
            ux = {1'b0, a_ff};
            uy = {1'b0, b_ff};
            usub = (op_ff == OP_SUB);
         end
         S_ABSA: begin
            uy = {1'b0, a_ff};
            usub = 1'b1;
         end
         S_ABSB: begin
            uy = {1'b0, b_ff};
            usub = 1'b1;
         end
         S_DIV: begin
            ux = rtmp;
            uy = {1'b0, ddiv_ff};
            usub = 1'b1;
         end
         S_DIVSGN: begin
            uy = {1'b0, dq_ff};
            usub = 1'b1;
         end
         S_GLOOP: begin
            ux = {1'b0, gx_ff};
            uy = {1'b0, gy_ff};
            usub = 1'b1;
         end
         S_MUL: begin
            ux = {1'b0, prod_ff[DATA_WIDTH-2:0], 1'b0};
            uy = {1'b0, mpl_ff[DATA_WIDTH-1] ? mca_ff : ZERO};
         end
         default: begin
            ux = '0;
         end
      endcase
   end

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      op_in = op_ff;
      a_in = a_ff;
      b_in = b_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      k_in = k_ff;
      cnt_in = cnt_ff;
      dq_in = dq_ff;
      drem_in = drem_ff;
      ddiv_in = ddiv_ff;
      mca_in = mca_ff;
      mpl_in = mpl_ff;
      prod_in = prod_ff;
      pacc_in = pacc_ff;
      res_in = res_ff;
      ovf_in = ovf_ff;
      neg_in = neg_ff;
      st_in = st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start_i) begin
               op_in = opcode_i;
               a_in = left_i;
               b_in = right_i;
               st_in = ST_OK;
               res_in = ZERO;
               neg_in = left_i[DATA_WIDTH-1] ^ right_i[DATA_WIDTH-1];
               cnt_in = '0;
               prod_in = ZERO;
               ovf_in = 1'b0;
               unique case (opcode_i) inside
                  OP_ADD, OP_SUB: state_in = S_ADDSUB;
                  OP_MUL: begin
                     mca_in = left_i;
                     mpl_in = right_i;
                     ret_in = S_MULFIN;
                     state_in = S_MUL;
                  end
                  OP_DIV: begin
                     if (right_i == ZERO) begin
                        st_in = ST_DIVZERO;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_ABSA;
                     end
                  end
                  OP_POW: begin
                     pacc_in = ONE;
                     state_in = right_i[DATA_WIDTH-1] ? S_DONE : S_PCHK;
                  end
                  OP_SAME: begin
                     res_in = {{(DATA_WIDTH - 1){1'b0}}, same};
                     state_in = S_DONE;
                  end
                  OP_GCD, OP_LCM: state_in = S_ABSA;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_ADDSUB: begin
            res_in = usum[DATA_WIDTH-1:0];
            state_in = S_DONE;
         end
         S_ABSA: begin
            if (a_ff[DATA_WIDTH-1]) begin
               a_in = usum[DATA_WIDTH-1:0];
            end
            state_in = S_ABSB;
         end
         S_ABSB: begin
            if (b_ff[DATA_WIDTH-1]) begin
               b_in = usum[DATA_WIDTH-1:0];
            end
            state_in = S_PREP;
         end
         S_PREP: begin
            cnt_in = '0;
            drem_in = ZERO;
            k_in = '0;
            gx_in = a_ff;
            gy_in = b_ff;
            if (op_ff == OP_DIV) begin
               dq_in = a_ff;
               ddiv_in = b_ff;
               ret_in = S_DIVSGN;
               state_in = S_DIV;
            end else if (a_ff == ZERO || b_ff == ZERO) begin
               // gcd with a zero operand is the other magnitude, saturated on overflow
               if (op_ff == OP_GCD) begin
                  if (a_ff[DATA_WIDTH-1] || b_ff[DATA_WIDTH-1]) begin
                     res_in = MAXPOS;
                     st_in = ST_OVERFLOW;
                  end else begin
                     res_in = a_ff | b_ff;
                  end
               end else begin
                  st_in = ST_ZERO;
               end
               state_in = S_DONE;
            end else begin
               state_in = S_GTWO;
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            if (ucarry) begin
               drem_in = usum[DATA_WIDTH-1:0];
            end else begin
               drem_in = rtmp[DATA_WIDTH-1:0];
            end
            dq_in = {dq_ff[DATA_WIDTH-2:0], ucarry};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ret_ff;
            end
         end
         S_DIVSGN: begin
            res_in = neg_ff ? usum[DATA_WIDTH-1:0] : dq_ff;
            state_in = S_DONE;
         end
         S_GTWO: begin
            // strip common factors of two
            if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in = gx_ff >> 1;
               gy_in = gy_ff >> 1;
               k_in = k_ff + 1'b1;
            end else begin
               state_in = S_GLOOP;
            end
         end
         S_GLOOP: begin
            if (gy_ff == ZERO) begin
               if (op_ff == OP_GCD) begin
                  if (gval[DATA_WIDTH-1]) begin
                     res_in = MAXPOS;
                     st_in = ST_OVERFLOW;
                  end else begin
                     res_in = gval;
                  end
                  state_in = S_DONE;
               end else begin
                  dq_in = a_ff;
                  ddiv_in = gval;
                  drem_in = ZERO;
                  cnt_in = '0;
                  ret_in = S_LCMMUL;
                  state_in = S_DIV;
               end
            end else if (!gx_ff[0]) begin
               gx_in = gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else if (!ucarry) begin
               gx_in = gy_ff;
               gy_in = gx_ff;
            end else if (usum[DATA_WIDTH-1:0] == ZERO) begin
               gy_in = ZERO;
            end else begin
               gx_in = usum[DATA_WIDTH-1:0];
            end
         end
         S_LCMMUL: begin
            mca_in = b_ff;
            mpl_in = dq_ff;
            prod_in = ZERO;
            ovf_in = 1'b0;
            cnt_in = '0;
            ret_in = S_LCMFIN;
            state_in = S_MUL;
         end
         S_LCMFIN: begin
            if (ovf_ff || prod_ff[DATA_WIDTH-1]) begin
               res_in = MAXPOS;
               st_in = ST_OVERFLOW;
            end else begin
               res_in = prod_ff;
            end
            state_in = S_DONE;
         end
         S_MUL: begin
            // msb-first shift and add, sticky flag when the product leaves the word
            prod_in = usum[DATA_WIDTH-1:0];
            ovf_in = ovf_ff | prod_ff[DATA_WIDTH-1] | usum[DATA_WIDTH];
            mpl_in = mpl_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ret_ff;
            end
         end
         S_MULFIN: begin
            res_in = prod_ff;
            state_in = S_DONE;
         end
         S_PCHK: begin
            prod_in = ZERO;
            cnt_in = '0;
            if (b_ff == ZERO) begin
               res_in = pacc_ff;
               state_in = S_DONE;
            end else if (b_ff[0]) begin
               mca_in = pacc_ff;
               mpl_in = a_ff;
               ret_in = S_PACC;
               state_in = S_MUL;
            end else begin
               state_in = S_PSQ;
            end
         end
         S_PACC: begin
            pacc_in = prod_ff;
            state_in = S_PSQ;
         end
         S_PSQ: begin
            b_in = b_ff >> 1;
            prod_in = ZERO;
            cnt_in = '0;
            if (b_ff[DATA_WIDTH-1:1] == '0) begin
               state_in = S_PCHK;
            end else begin
               mca_in = a_ff;
               mpl_in = a_ff;
               ret_in = S_PBASE;
               state_in = S_MUL;
            end
         end
         S_PBASE: begin
            a_in = prod_ff;
            state_in = S_PCHK;
         end
         S_DONE: begin
            if (take_i) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;
      op_ff <= op_in;
      a_ff <= a_in;
      b_ff <= b_in;
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      k_ff <= k_in;
      cnt_ff <= cnt_in;
      dq_ff <= dq_in;
      drem_ff <= drem_in;
      ddiv_ff <= ddiv_in;
      mca_ff <= mca_in;
      mpl_ff <= mpl_in;
      prod_ff <= prod_in;
      pacc_ff <= pacc_in;
      res_ff <= res_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
      st_ff <= st_in;
   end

   assign stat_o.idle = (state_ff == S_IDLE);
   assign stat_o.done = (state_ff == S_DONE);
   assign value_o = res_ff;
   assign status_o = st_ff;

endmodule

// ===== rtl/core/integer_calculator_alu.sv =====
// ----------------------------------------------------------------------------
// integer_calculator_alu
// integer alu: add, sub, mul, div, power, same sign, gcd, lcm on signed words
// ----------------------------------------------------------------------------
//
// channel   dir   transfer          payload
// req_      in    tvalid & tready   tuser: opcode, tdata: left, right operand
// rsp_      out   tvalid & tready   tuser: status, tdata: value
//
// one item in the sequencer, one result waiting; req_tready is high only
// while the sequencer is idle; every operation but add, sub and same sign
// iterates on the single shared adder / subtractor, mul and div stepping
// one bit a cycle
// the result register lets the sequencer finish while a result waits,
// a full result register stalls the sequencer in its done state
// synchronous active-high reset clears control state only
module integer_calculator_alu #(
   parameter int DATA_WIDTH = icalc_pkg::DATA_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // left_operand, right_operand from bit 0 up, zero padded
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]       req_tdata,
   // opcode
   input  icalc_pkg::opcode_type                  req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // value, zero padded
   output logic [((DATA_WIDTH+7)/8)*8-1:0]         rsp_tdata,
   // status
   output icalc_pkg::status_type                  rsp_tuser
);
   import icalc_pkg::*;

   localparam int RSP_DW = ((DATA_WIDTH + 7) / 8) * 8;
   localparam logic [DATA_WIDTH-1:0] MAXPOS = {1'b0, {(DATA_WIDTH - 1){1'b1}}};

   core_stat_type stat;
   logic start, take;
   logic [DATA_WIDTH-1:0] core_value;
   status_type core_status;

   logic rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   status_type rsp_status_ff, rsp_status_in;

   // input transfer only while the sequencer is idle
   assign req_tready = stat.idle;
   assign start = req_tvalid & req_tready;

   // move the finished result into the output register when it is free
   assign take = stat.done & (~rsp_valid_ff | rsp_tready);

   icalc_core #(.DATA_WIDTH(DATA_WIDTH)) u_core (
      .clock   (clock),
      .reset   (reset),
      .start_i (start),
      .opcode_i(req_tuser),
      .left_i  (req_tdata[DATA_WIDTH-1:0]),
      .right_i (req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
      .take_i  (take),
      .stat_o  (stat),
      .value_o (core_value),
      .status_o(core_status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = core_value;
         rsp_status_in = core_status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_DW'(rsp_value_ff);
   assign rsp_tuser = rsp_status_ff;

   // a transfer in always leaves the sequencer busy on the next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_tready)
      else $error("sequencer ready right after a transfer in");

   // error statuses carry their fixed values
   a_divzero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_DIVZERO || rsp_tuser == ST_ZERO)
      |-> rsp_tdata[DATA_WIDTH-1:0] == '0)
      else $error("nonzero value with divide-by-zero or zero-operand status");

   a_overflow_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_OVERFLOW |-> rsp_tdata[DATA_WIDTH-1:0] == MAXPOS)
      else $error("overflow status without saturated value");

   // the sequencer never hands a result over while the result register is held back
   a_no_lost_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("held result dropped");

endmodule

// ===== bench/integer_calculator_alu_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_calculator_alu_tb
// self-checking bench: directed corner operands, then random operand streams
// with random request gaps and, in all but the last, receiver stalls; each
// result is compared with an in-bench model of the alu, in transfer order
// ----------------------------------------------------------------------------
module integer_calculator_alu_tb;
   import icalc_pkg::*;

   localparam int W = 32;
   localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic [W-1:0] value;
      status_type   status;
   } alu_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [63:0] req_tdata;   // left_operand, right_operand
   opcode_type req_tuser;    // opcode
   logic rsp_tvalid;
   logic rsp_tready;
   logic [31:0] rsp_tdata;   // value
   status_type rsp_tuser;    // status

   alu_result_type pending_results[$];
   int error_count;
   int result_count;
   int item_count;
   int hold_cycles;          // long receiver hold-off, counted by the receiver
   bit random_ready;

   integer_calculator_alu #(.DATA_WIDTH(W)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // magnitude of a two's complement word, as an unsigned 33-bit number
   function automatic logic [W:0] abs_word(logic [W-1:0] x);
      return x[W-1] ? {1'b0, -x} : {1'b0, x};
   endfunction

   function automatic logic [W:0] euclid(logic [W:0] a, logic [W:0] b);
      logic [W:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic alu_result_type alu_predict(opcode_type op, logic [W-1:0] a,
                                                  logic [W-1:0] b);
      alu_result_type r;
      logic [W:0] ma, mb, g, q;
      logic [W-1:0] base, acc;
      r.value = '0;
      r.status = ST_OK;
      ma = abs_word(a);
      mb = abs_word(b);
      case (op)
         OP_ADD: r.value = a + b;
         OP_SUB: r.value = a - b;
         OP_MUL: r.value = a * b;
         OP_DIV: begin
            if (b == 0) r.status = ST_DIVZERO;
            else begin
               q = ma / mb;
               r.value = (a[W-1] != b[W-1]) ? -q[W-1:0] : q[W-1:0];
            end
         end
         OP_POW: begin
            if (!b[W-1]) begin
               // square and multiply over every exponent bit, wrapping
               acc = 1;
               base = a;
               for (int i = 0; i < W; i++) begin
                  if (b[i]) acc = acc * base;
                  base = base * base;
               end
               r.value = acc;
            end
         end
         OP_SAME: r.value = ((!a[W-1] && a != 0 && !b[W-1] && b != 0) ||
                             (a[W-1] && b[W-1])) ? 1 : 0;
         OP_GCD: begin
            g = euclid(ma, mb);
            if (g > MAXPOS) begin
               r.value = MAXPOS;
               r.status = ST_OVERFLOW;
            end else r.value = g[W-1:0];
         end
         default: begin
            if (ma == 0 || mb == 0) r.status = ST_ZERO;
            else begin
               q = ma / euclid(ma, mb);
               if (q > MAXPOS / mb) begin
                  r.value = MAXPOS;
                  r.status = ST_OVERFLOW;
               end else r.value = W'(q * mb);
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
      error_count++;
      $display("mismatch %s: got %h, expected %h (result %0d)", what, got, want,
               result_count);
   endtask

   // one request transfer, after a random gap; valid stays up after the
   // transfer until the next gap or the next item replaces it
   task automatic send_item(opcode_type op, logic [W-1:0] a, logic [W-1:0] b);
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(alu_predict(op, a, b));
      item_count++;
   endtask

   // receiver: random stalls, or a long hold-off when requested
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            while (hold_cycles > 0) begin
               @(posedge clock);
               hold_cycles--;
            end
         end
         stall = random_ready ? $urandom_range(0, 4) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // result checker, sampled at the edge
   always @(posedge clock) begin
      alu_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (pending_results.size() == 0) begin
            error_count++;
            $display("unexpected result transfer %h / %0d", rsp_tdata, rsp_tuser);
         end else begin
            e = pending_results.pop_front();
            if (rsp_tdata !== e.value) report_mismatch("value", rsp_tdata, e.value);
            if (rsp_tuser !== e.status)
               report_mismatch("status", W'(rsp_tuser), W'(e.status));
         end
      end
   end

   function automatic logic [W-1:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 16) - 8;
         1: return MAXPOS - $urandom_range(0, 3);
         2: return MINNEG + $urandom_range(0, 3);
         3: return $urandom_range(0, 1000) * (($urandom_range(0, 1) != 0) ? 1 : -1);
         4: return $urandom & ({W{1'b1}} >> $urandom_range(1, W - 1));
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [W-1:0] corners[6];
      corners = '{32'd0, 32'd1, 32'hFFFF_FFFF, MAXPOS, MINNEG, 32'd12};
      send_item(OP_DIV, 32'd7, 32'd0);
      send_item(OP_DIV, MINNEG, 32'hFFFF_FFFF);
      send_item(OP_DIV, -32'sd7, 32'd2);
      send_item(OP_POW, 32'd3, -32'sd1);
      send_item(OP_POW, 32'd0, 32'd0);
      send_item(OP_POW, 32'd3, 32'd19);
      send_item(OP_POW, 32'hFFFF_FFFF, MAXPOS);
      send_item(OP_GCD, -32'sd18, 32'd0);
      send_item(OP_GCD, 32'd0, 32'd0);
      send_item(OP_GCD, MINNEG, MINNEG);
      send_item(OP_GCD, MINNEG, 32'd0);
      send_item(OP_LCM, 32'd0, 32'd5);
      send_item(OP_LCM, MAXPOS, MAXPOS - 1);
      send_item(OP_LCM, -32'sd4, 32'd6);
      send_item(OP_SAME, 32'd0, 32'd5);
      send_item(OP_SAME, MINNEG, 32'hFFFF_FFFF);
      for (int op = 0; op < 8; op++)
         send_item(opcode_type'(op), corners[$urandom_range(0, 5)],
                   corners[$urandom_range(0, 5)]);
      wait_drained();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         send_item(opcode_type'($urandom_range(0, 7)), rand_operand(), rand_operand());
   endtask

   // receiver holds off while the sender keeps offering, then drain fully
   task automatic test_backpressure();
      hold_cycles = 400;
      test_random(20);
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_ADD;
      error_count = 0;
      result_count = 0;
      item_count = 0;
      hold_cycles = 0;
      random_ready = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(800);
      wait_drained();
      random_ready = 1'b0;
      test_random(850);
      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d requests, %0d results, all opcodes with corner operands,",
               item_count, result_count);
      $display("random gaps and stalls, one long output hold-off");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("integer_calculator_alu_tb: done, clean");
      end else begin
         $display("integer_calculator_alu_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #500ms;
      $display("integer_calculator_alu_tb: done, errors");
      $finish;
   end

endmodule
